// ===== hdl/clarke_pi_current_controller_defines.svh =====
// Assertion macros used by the controller back end, cpcc_back.
// Used by files that take them by include; expects aclk and aresetn in scope.
`ifndef CLARKE_PI_CURRENT_CONTROLLER_DEFINES_SVH
`define CLARKE_PI_CURRENT_CONTROLLER_DEFINES_SVH

// plain property, checked outside reset
`define CPCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define CPCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/cpcc_pkg.sv =====
// Package for the Clarke-frame PI current controller.
// Holds item and result layouts, register indexes, fixed-point constants and helpers.
`timescale 1ns / 1ps

package cpcc_pkg;

    localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [1:0] REG_OUT_MIN    = 2'd2;
    localparam logic [1:0] REG_OUT_MAX    = 2'd3;

    localparam logic [1:0] SAT_NONE = 2'b00;
    localparam logic [1:0] SAT_HIGH = 2'b01;
    localparam logic [1:0] SAT_LOW  = 2'b11;

    localparam logic signed [17:0] SQRT3_HALF_Q16 = 18'sd56756;
    localparam logic signed [19:0] OUT_MIN_RST    = -20'sd262144;
    localparam logic signed [19:0] OUT_MAX_RST    = 20'sd261120;

    typedef struct packed {
        logic [1:0]         pad;
        logic [11:0]        adc_c;
        logic [11:0]        adc_b;
        logic [11:0]        adc_a;
        logic signed [15:0] ref_beta;
        logic signed [15:0] ref_alpha;
        logic               ctrl_enable;
        logic               rst_integral_n;
    } cpcc_in_t;

    typedef struct packed {
        logic [4:0]        pad;
        logic signed [7:0] scope_y_beta;
        logic signed [7:0] scope_y_alpha;
        logic signed [7:0] scope_i_beta;
        logic signed [7:0] scope_i_alpha;
        logic signed [8:0] duty_c;
        logic signed [8:0] duty_b;
        logic signed [8:0] duty_a;
    } cpcc_result_t;

    typedef struct packed {
        logic               rst_n;
        logic               ena;
        logic signed [15:0] ra;
        logic signed [15:0] rb;
        logic signed [13:0] ia;
        logic signed [13:0] ib;
        logic signed [17:0] ea;
        logic signed [17:0] eb;
    } cpcc_item_t;

    function automatic logic signed [8:0] sat9(input logic signed [19:0] x);
        logic signed [8:0] r;
        if (x < -20'sd256) begin
            r = -9'sd256;
        end else if (x > 20'sd255) begin
            r = 9'sd255;
        end else begin
            r = x[8:0];
        end
        return r;
    endfunction

    function automatic logic signed [7:0] sat8(input logic signed [9:0] x);
        logic signed [7:0] r;
        if (x < -10'sd128) begin
            r = -8'sd128;
        end else if (x > 10'sd127) begin
            r = 8'sd127;
        end else begin
            r = x[7:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/cpcc_front.sv =====
// Front end: accepts samples, scales ADC codes and forms the Clarke currents and errors.
// Depends on cpcc_pkg; feeds cpcc_queue.
`timescale 1ns / 1ps

module cpcc_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [71:0]           s_tdata,
    output logic                  q_push,
    output cpcc_pkg::cpcc_item_t  q_item,
    input  logic                  q_full
);
    import cpcc_pkg::*;

    cpcc_in_t           in_f;
    logic signed [11:0] ca, cb, cc;
    logic signed [14:0] ia_num;
    logic signed [12:0] dbc;
    logic signed [29:0] pbc;
    logic signed [29:0] ib_full;
    logic signed [13:0] ib;
    logic               accept;

    logic               v1_reg;
    logic               rst_n_reg, ena_reg;
    logic signed [15:0] ra_reg, rb_reg;
    logic signed [13:0] ia_reg;
    logic signed [29:0] pbc_reg;

    assign in_f   = cpcc_in_t'(s_tdata);
    assign ca     = {~in_f.adc_a[11], in_f.adc_a[10:0]};
    assign cb     = {~in_f.adc_b[11], in_f.adc_b[10:0]};
    assign cc     = {~in_f.adc_c[11], in_f.adc_c[10:0]};
    assign ia_num = (15'(ca) <<< 1) - 15'(cb) - 15'(cc) + 15'sd1;
    assign dbc    = 13'(cb) - 13'(cc);
    assign pbc    = 30'(dbc) * 30'(SQRT3_HALF_Q16);

    assign s_tready = !v1_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = v1_reg && !q_full;

    assign ib_full = pbc_reg + 30'sd32768;
    assign ib      = ib_full[29:16];

    always_comb begin
        q_item       = '0;
        q_item.rst_n = rst_n_reg;
        q_item.ena   = ena_reg;
        q_item.ra    = ra_reg;
        q_item.rb    = rb_reg;
        q_item.ia    = ia_reg;
        q_item.ib    = ib;
        q_item.ea    = 18'(ra_reg) - 18'(ia_reg);
        q_item.eb    = 18'(rb_reg) - 18'(ib);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (accept) begin
            v1_reg <= 1'b1;
        end else if (q_push) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rst_n_reg <= in_f.rst_integral_n;
            ena_reg   <= in_f.ctrl_enable;
            ra_reg    <= in_f.ref_alpha;
            rb_reg    <= in_f.ref_beta;
            ia_reg    <= ia_num[14:1];
            pbc_reg   <= pbc;
        end
    end

endmodule

// ===== hdl/cpcc_queue.sv =====
// Short item queue between the front end and the PI back end.
// Depends on cpcc_pkg for the item layout.
`timescale 1ns / 1ps

module cpcc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  cpcc_pkg::cpcc_item_t  wr_item,
    output logic                  full,
    input  logic                  pop,
    output cpcc_pkg::cpcc_item_t  rd_item,
    output logic                  empty
);
    import cpcc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cpcc_item_t        slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== hdl/cpcc_back.sv =====
// Back end: PI control with anti-windup, inverse Clarke and the output register.
// Depends on cpcc_pkg and the assertion macros; one shared multiplier, eight steps an item.
`timescale 1ns / 1ps
`include "clarke_pi_current_controller_defines.svh"

module cpcc_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_index,
    input  logic [23:0]            cfg_wdata,
    input  cpcc_pkg::cpcc_item_t   head,
    input  logic                   q_empty,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output cpcc_pkg::cpcc_result_t m_result
);
    import cpcc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MIB  = 3'd1;
    localparam logic [2:0] S_MPA  = 3'd2;
    localparam logic [2:0] S_MPB  = 3'd3;
    localparam logic [2:0] S_PIA  = 3'd4;
    localparam logic [2:0] S_PIB  = 3'd5;
    localparam logic [2:0] S_DRV  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic signed [23:0]  pg_reg, ig_reg;
    logic signed [19:0]  out_min_reg, out_max_reg;
    logic signed [19:0]  integ_a_reg, integ_b_reg, pi_a_reg, pi_b_reg;
    logic [1:0]          sat_reg;
    cpcc_item_t          item_reg;
    logic                frozen_reg;
    logic signed [44:0]  prod_reg;
    logic signed [28:0]  gia_reg, gib_reg, gpa_reg, gpb_reg;
    logic                m_tvalid_reg;
    cpcc_result_t        res_reg;

    logic signed [23:0]  mul_a;
    logic signed [20:0]  mul_b;
    logic signed [44:0]  mul_p;
    logic signed [44:0]  prod_rnd;
    logic signed [28:0]  rnd_q;
    logic signed [20:0]  dbe, dal;
    logic                frozen_c;
    logic signed [19:0]  base_a, base_b;
    logic signed [29:0]  na, nb, lo30, hi30;
    logic signed [45:0]  h46, p46, sb, sc;
    logic signed [20:0]  ta;
    logic signed [13:0]  ti_a, ti_b;
    logic signed [19:0]  ty_a, ty_b;
    cpcc_result_t        res_c;
    logic                out_load;

    function automatic logic signed [19:0] pi_clamp(input logic signed [28:0] gp,
                                                    input logic signed [19:0] integ,
                                                    input logic signed [19:0] lo,
                                                    input logic signed [19:0] hi);
        logic signed [29:0] y;
        y = 30'(gp) + 30'(integ);
        y = (y > 30'(lo)) ? y : 30'(lo);
        y = (y < 30'(hi)) ? y : 30'(hi);
        return y[19:0];
    endfunction

    function automatic logic signed [19:0] trunc26(input logic signed [45:0] s);
        logic signed [45:0] t;
        t = (s + (s[45] ? 46'sd67108863 : 46'sd0)) >>> 26;
        return t[19:0];
    endfunction

    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign frozen_c = ((sat_reg == SAT_LOW) && (head.ea < 18'sd0)) ||
                      ((sat_reg == SAT_HIGH) && (head.ea > 18'sd0));
    assign dbe      = item_reg.ena ? -21'(pi_b_reg) : 21'(item_reg.rb);
    assign dal      = item_reg.ena ? -21'(pi_a_reg) : 21'(item_reg.ra);

    always_comb begin
        case (state_reg)
            S_IDLE: begin
                mul_a = ig_reg;
                mul_b = 21'(head.ea);
            end
            S_MIB: begin
                mul_a = ig_reg;
                mul_b = 21'(item_reg.eb);
            end
            S_MPA: begin
                mul_a = pg_reg;
                mul_b = 21'(item_reg.ea);
            end
            S_MPB: begin
                mul_a = pg_reg;
                mul_b = 21'(item_reg.eb);
            end
            S_DRV: begin
                mul_a = 24'(SQRT3_HALF_Q16);
                mul_b = dbe;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = 45'(mul_a) * 45'(mul_b);
    assign prod_rnd = prod_reg + 45'sd32768;
    assign rnd_q    = prod_rnd[44:16];

    assign base_a = item_reg.rst_n ? integ_a_reg : 20'sd0;
    assign base_b = item_reg.rst_n ? integ_b_reg : 20'sd0;
    assign na     = 30'(base_a) + 30'(gia_reg);
    assign nb     = 30'(base_b) + 30'(gib_reg);
    assign lo30   = 30'(out_min_reg);
    assign hi30   = 30'(out_max_reg);

    assign h46 = -(46'(dal) <<< 15);
    assign p46 = 46'(prod_reg);
    assign sb  = h46 + p46;
    assign sc  = h46 - p46;
    assign ta  = (dal + (dal[20] ? 21'sd1023 : 21'sd0)) >>> 10;
    assign ti_a = (item_reg.ia + (item_reg.ia[13] ? 14'sd15 : 14'sd0)) >>> 4;
    assign ti_b = (item_reg.ib + (item_reg.ib[13] ? 14'sd15 : 14'sd0)) >>> 4;
    assign ty_a = (pi_a_reg + (pi_a_reg[19] ? 20'sd1023 : 20'sd0)) >>> 10;
    assign ty_b = (pi_b_reg + (pi_b_reg[19] ? 20'sd1023 : 20'sd0)) >>> 10;

    always_comb begin
        res_c               = '0;
        res_c.duty_a        = sat9(20'(ta));
        res_c.duty_b        = sat9(trunc26(sb));
        res_c.duty_c        = sat9(trunc26(sc));
        res_c.scope_i_alpha = sat8(ti_a[9:0]);
        res_c.scope_i_beta  = sat8(ti_b[9:0]);
        res_c.scope_y_alpha = sat8(ty_a[9:0]);
        res_c.scope_y_beta  = sat8(ty_b[9:0]);
    end

    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (!q_empty) state_next = S_MIB;
            S_MIB:   state_next = S_MPA;
            S_MPA:   state_next = S_MPB;
            S_MPB:   state_next = S_PIA;
            S_PIA:   state_next = S_PIB;
            S_PIB:   state_next = S_DRV;
            S_DRV:   state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            pg_reg       <= '0;
            ig_reg       <= '0;
            out_min_reg  <= OUT_MIN_RST;
            out_max_reg  <= OUT_MAX_RST;
            integ_a_reg  <= '0;
            integ_b_reg  <= '0;
            pi_a_reg     <= '0;
            pi_b_reg     <= '0;
            sat_reg      <= SAT_NONE;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PROP_GAIN:  pg_reg      <= cfg_wdata;
                    REG_INTEG_GAIN: ig_reg      <= cfg_wdata;
                    REG_OUT_MIN:    out_min_reg <= cfg_wdata[19:0];
                    REG_OUT_MAX:    out_max_reg <= cfg_wdata[19:0];
                    default: ;
                endcase
            end
            if (state_reg == S_MPB) begin
                if (frozen_reg) begin
                    integ_a_reg <= base_a;
                    integ_b_reg <= base_b;
                end else if (na < lo30) begin
                    integ_a_reg <= out_min_reg;
                    integ_b_reg <= out_min_reg;
                    sat_reg     <= SAT_LOW;
                end else if (na > hi30) begin
                    integ_a_reg <= out_max_reg;
                    integ_b_reg <= out_max_reg;
                    sat_reg     <= SAT_HIGH;
                end else begin
                    integ_a_reg <= na[19:0];
                    if (nb < -30'sd524288) begin
                        integ_b_reg <= -20'sd524288;
                    end else if (nb > 30'sd524287) begin
                        integ_b_reg <= 20'sd524287;
                    end else begin
                        integ_b_reg <= nb[19:0];
                    end
                    sat_reg <= SAT_NONE;
                end
            end
            if (state_reg == S_PIA && !frozen_reg) begin
                pi_a_reg <= pi_clamp(gpa_reg, integ_a_reg, out_min_reg, out_max_reg);
            end
            if (state_reg == S_PIB && !frozen_reg) begin
                pi_b_reg <= pi_clamp(gpb_reg, integ_b_reg, out_min_reg, out_max_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg   <= head;
            frozen_reg <= frozen_c;
        end
        if (q_pop || (state_reg inside {S_MIB, S_MPA, S_MPB, S_DRV})) begin
            prod_reg <= mul_p;
        end
        if (state_reg == S_MIB) gia_reg <= rnd_q;
        if (state_reg == S_MPA) gib_reg <= rnd_q;
        if (state_reg == S_MPB) gpa_reg <= rnd_q;
        if (state_reg == S_PIA) gpb_reg <= rnd_q;
        if (out_load) res_reg <= res_c;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_result = res_reg;

    `CPCC_ASSERT_NEXT(a_out_returns_idle, (state_reg == S_OUT) && out_load, (state_reg == S_IDLE) && m_tvalid_reg, "result load did not return to idle with valid output")
    `CPCC_ASSERT_NEXT(a_frozen_holds_pi, (state_reg == S_PIA) && frozen_reg, $stable(pi_a_reg), "PI output changed on a frozen sample")
    `CPCC_ASSERT_NEXT(a_integ_in_limits, (state_reg == S_MPB) && !frozen_reg && (out_min_reg <= out_max_reg), (integ_a_reg >= out_min_reg) && (integ_a_reg <= out_max_reg), "alpha integral left its limits")

endmodule

// ===== hdl/clarke_pi_current_controller.sv =====
// Top level of the Clarke-frame PI current controller.
// Instantiates cpcc_front, cpcc_queue and cpcc_back; depends on cpcc_pkg.
//
// Usage:
//   s_ channel carries one sample per item: integral clear, control enable, alpha/beta
//   references and three phase-current ADC codes. m_ channel returns one result item
//   per sample: three saturated duty values and four scope values.
//   cfg_wr_en/cfg_index/cfg_wdata write prop_gain, integ_gain, out_min and out_max;
//   write them only while no sample is in flight.
//   The back end finishes one item before it takes the next from the queue; its single shared
//   multiplier runs four gain products and one inverse Clarke product per item.
//   The front end and a two-entry queue keep taking items while the back end works.
//   Reset clears integrals, PI outputs and the saturation flag and loads the default
//   gains and limits. When m_tready is low the result holds in the output register,
//   the back end waits with the next result ready, and s_tready drops once the queue
//   and the front register are full.
`timescale 1ns / 1ps

module clarke_pi_current_controller #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // rst_integral_n, ctrl_enable, ref_alpha, ref_beta, adc_a, adc_b, adc_c, zero pad
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // duty_a, duty_b, duty_c, scope_i_alpha, scope_i_beta, scope_y_alpha, scope_y_beta, pad
    output logic [63:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);
    import cpcc_pkg::*;

    cpcc_item_t   push_item, head_item;
    logic         q_push, q_full, q_pop, q_empty;
    cpcc_result_t result;

    cpcc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_push   (q_push),
        .q_item   (push_item),
        .q_full   (q_full)
    );

    cpcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_item (push_item),
        .full    (q_full),
        .pop     (q_pop),
        .rd_item (head_item),
        .empty   (q_empty)
    );

    cpcc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .head      (head_item),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (result)
    );

    assign m_tdata = result;

endmodule
